// ----- rtl/pcfv_pkg.sv -----
// Shared constants and rounding and saturation helpers for the contact frame pipeline.
// No dependencies.
package pcfv_pkg;

  localparam int unsigned UNIT_SH   = 30;
  localparam int unsigned SQ_STEPS  = 32;
  localparam int unsigned DIV_STEPS = 31;
  localparam int unsigned UNIT_LAT  = 9 + SQ_STEPS + DIV_STEPS + 1;

  localparam logic signed [67:0] RND_HALF = 68'sd1 <<< (UNIT_SH - 1);
  localparam logic signed [67:0] SAT_MAX  = 68'sh7FFFFFFF;
  localparam logic signed [67:0] SAT_MIN  = -68'sh80000000;

  function automatic logic signed [67:0] rnd_shr(input logic signed [67:0] x);
    return (x + RND_HALF) >>> UNIT_SH;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [67:0] x);
    logic [31:0] r;
    if (x > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/pcfv_unit.sv -----
// Pipelined vector normalizer: scale, sum of squares, bit-serial sqrt, divide.
// Uses pcfv_pkg.
module pcfv_unit
  import pcfv_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2:0][63:0] comp_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [2:0][31:0] unit_o,
  output logic [SideW-1:0] side_o
);

  logic [UNIT_LAT-1:0] vl_q;
  logic [SideW+2:0]    dl_q [UNIT_LAT];

  logic [2:0][63:0] m0_q, m1_q, m2_q, m3_q, m4_q;
  logic [63:0]      mx1_q, mx2_q;
  logic [7:0]       gnz_q, gnz_d;
  logic [7:0][3:0]  glz_q, glz_d;
  logic [6:0]       bl_q, bl_d;
  logic [2:0][29:0] ms5_q, ms5_d, ms6_q, ms7_q;
  logic [2:0][59:0] sq6_q;
  logic [61:0]      n27_q;

  logic [62:0]      sn_q [SQ_STEPS];
  logic [62:0]      sn_d [SQ_STEPS];
  logic [62:0]      sr_q [SQ_STEPS];
  logic [62:0]      sr_d [SQ_STEPS];
  logic [2:0][29:0] msp_q [SQ_STEPS];

  logic [2:0][60:0] drem_q [DIV_STEPS+1];
  logic [2:0][60:0] drem_d [DIV_STEPS+1];
  logic [2:0][30:0] dq_q [DIV_STEPS+1];
  logic [2:0][30:0] dq_d [DIV_STEPS+1];
  logic [30:0]      ddv_q [DIV_STEPS+1];
  logic [30:0]      ddv_d [DIV_STEPS+1];

  logic [2:0][31:0] u_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else if (en_i) begin
      vl_q <= {vl_q[UNIT_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q[0] <= {comp_i[2][63], comp_i[1][63], comp_i[0][63], side_i};
      for (int k = 1; k < UNIT_LAT; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      gnz_d[g] = |mx2_q[8*g +: 8];
      glz_d[g] = 4'd8;
      for (int b = 0; b < 8; b++) begin
        if (mx2_q[8*g+b]) begin
          glz_d[g] = 4'(7 - b);
        end
      end
    end
  end

  always_comb begin
    bl_d = '0;
    for (int g = 0; g < 8; g++) begin
      if (gnz_q[g]) begin
        bl_d = 7'(8*g + 8) - {3'b0, glz_q[g]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl_q > 7'(UNIT_SH)) begin
        ms5_d[i] = 30'(m4_q[i] >> (bl_q - 7'(UNIT_SH)));
      end else begin
        ms5_d[i] = 30'(m4_q[i] << (7'(UNIT_SH) - bl_q));
      end
    end
  end

  always_comb begin
    logic [62:0] nin, rin, bitv, trial;
    for (int k = 0; k < SQ_STEPS; k++) begin
      nin   = (k == 0) ? {1'b0, n27_q} : sn_q[(k == 0) ? 0 : k-1];
      rin   = (k == 0) ? '0 : sr_q[(k == 0) ? 0 : k-1];
      bitv  = 63'(1) << (2 * (SQ_STEPS - 1 - k));
      trial = rin + bitv;
      if (nin >= trial) begin
        sn_d[k] = nin - trial;
        sr_d[k] = (rin >> 1) + bitv;
      end else begin
        sn_d[k] = nin;
        sr_d[k] = rin >> 1;
      end
    end
  end

  always_comb begin
    logic [30:0] root;
    logic [60:0] sub;
    root      = sr_q[SQ_STEPS-1][30:0];
    ddv_d[0]  = root;
    dq_d[0]   = '0;
    for (int i = 0; i < 3; i++) begin
      drem_d[0][i] = {1'b0, msp_q[SQ_STEPS-1][i], {UNIT_SH{1'b0}}} + 61'(root >> 1);
    end
    for (int s = 1; s <= DIV_STEPS; s++) begin
      ddv_d[s] = ddv_q[s-1];
      sub      = 61'(ddv_q[s-1]) << (DIV_STEPS - s);
      for (int i = 0; i < 3; i++) begin
        if (drem_q[s-1][i] >= sub) begin
          drem_d[s][i] = drem_q[s-1][i] - sub;
          dq_d[s][i]   = dq_q[s-1][i] | (31'(1) << (DIV_STEPS - s));
        end else begin
          drem_d[s][i] = drem_q[s-1][i];
          dq_d[s][i]   = dq_q[s-1][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        m0_q[i] <= comp_i[i][63] ? 64'd0 - comp_i[i] : comp_i[i];
      end
      m1_q  <= m0_q;
      mx1_q <= (m0_q[0] > m0_q[1]) ? m0_q[0] : m0_q[1];
      m2_q  <= m1_q;
      mx2_q <= (mx1_q > m1_q[2]) ? mx1_q : m1_q[2];
      m3_q  <= m2_q;
      gnz_q <= gnz_d;
      glz_q <= glz_d;
      m4_q  <= m3_q;
      bl_q  <= bl_d;
      ms5_q <= ms5_d;
      ms6_q <= ms5_q;
      for (int i = 0; i < 3; i++) begin
        sq6_q[i] <= ms5_q[i] * ms5_q[i];
      end
      ms7_q <= ms6_q;
      n27_q <= 62'(sq6_q[0]) + 62'(sq6_q[1]) + 62'(sq6_q[2]);
      msp_q[0] <= ms7_q;
      for (int k = 0; k < SQ_STEPS; k++) begin
        sn_q[k] <= sn_d[k];
        sr_q[k] <= sr_d[k];
      end
      for (int k = 1; k < SQ_STEPS; k++) begin
        msp_q[k] <= msp_q[k-1];
      end
      for (int s = 0; s <= DIV_STEPS; s++) begin
        drem_q[s] <= drem_d[s];
        dq_q[s]   <= dq_d[s];
        ddv_q[s]  <= ddv_d[s];
      end
      for (int i = 0; i < 3; i++) begin
        u_q[i] <= dl_q[UNIT_LAT-2][SideW+i] ? 32'd0 - {1'b0, dq_q[DIV_STEPS][i]}
                                             : {1'b0, dq_q[DIV_STEPS][i]};
      end
    end
  end

  assign valid_o = vl_q[UNIT_LAT-1];
  assign unit_o  = u_q;
  assign side_o  = dl_q[UNIT_LAT-1][SideW-1:0];

endmodule

// ----- rtl/pair_contact_frame_velocity.sv -----
// Contact frame of a particle pair: frame velocity and contact origin.
// Pipeline: 3 test stages, two 73-stage normalizers, 11 product stages.
// Throughput one word per cycle; the whole pipeline holds while the output stalls.
// Reset clears all valid bits; payload registers are not reset.
// Uses pcfv_pkg and pcfv_unit.
module pair_contact_frame_velocity
  import pcfv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] center_a_x_i,
  input  logic signed [31:0] center_a_y_i,
  input  logic signed [31:0] center_a_z_i,
  input  logic signed [31:0] center_b_x_i,
  input  logic signed [31:0] center_b_y_i,
  input  logic signed [31:0] center_b_z_i,
  input  logic signed [31:0] rel_vel_x_i,
  input  logic signed [31:0] rel_vel_y_i,
  input  logic signed [31:0] rel_vel_z_i,
  input  logic        [30:0] radius_a_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] frame_vel_x_o,
  output logic signed [31:0] frame_vel_y_o,
  output logic signed [31:0] frame_vel_z_o,
  output logic signed [31:0] origin_x_o,
  output logic signed [31:0] origin_y_o,
  output logic signed [31:0] origin_z_o,
  output logic               aligned_o,
  output logic               coincident_o
);

  typedef struct packed {
    logic             co;
    logic             alx;
    logic [30:0]      rad;
    logic [2:0][31:0] a;
    logic [2:0][31:0] v;
  } s1_t;

  typedef struct packed {
    s1_t              s;
    logic [2:0][31:0] ez;
    logic [2:0][63:0] fb;
    logic [2:0][31:0] org;
    logic [31:0]      fvz;
  } mid_t;

  typedef struct packed {
    logic             co;
    logic             al;
    logic [31:0]      fvz;
    logic [2:0][31:0] org;
    logic [2:0][31:0] ez;
    logic [2:0][31:0] v;
  } s2_t;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  s1_t              e1_q, e2_q, e3_q;
  logic [2:0][32:0] d1_q, d2_q, d3_q;
  logic signed [64:0] p2_q [3];
  logic signed [64:0] q2_q [3];
  logic [2:0][63:0] c1_in;

  logic             u1_v;
  logic [2:0][31:0] ez1;
  s1_t              u1s;

  logic signed [63:0] pv4_q [3];
  logic signed [63:0] pr4_q [3];
  logic [2:0][63:0]   fb4_d;
  mid_t               m4_q, m5_q, m6_q, m7_q, m8_q;
  logic signed [63:0] uz5_q, uzh;
  logic signed [65:0] hu6_q [3];
  logic signed [62:0] lu6_q [3];
  logic signed [65:0] t7_q [3];
  logic signed [63:0] w8_q [3];
  logic [2:0][63:0]   c9_q;
  s2_t                s9_q;

  logic             u2_v;
  logic [2:0][31:0] ex2;
  s2_t              u2s;

  logic signed [63:0] cp_q [6];
  logic signed [63:0] pvx_q [3];
  logic signed [33:0] ey_q [3];
  logic signed [65:0] ux_q;
  logic signed [65:0] pvy_q [3];
  logic signed [67:0] uy_q;
  logic [31:0]        fvx_c_q, fvx_d_q;
  s2_t                sa_q, sb_q, sc_q, sd_q;

  logic [31:0] fvx_q, fvy_q, fvz_q, ox_q, oy_q, oz_q;
  logic        al_q, co_q;

  assign en      = !(ve_q && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
      {va_q, vb_q, vc_q, vd_q, ve_q} <= '0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= u1_v;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
      va_q <= u2_v;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  // pair setup and exact parallel test
  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q.a   <= {center_a_z_i, center_a_y_i, center_a_x_i};
      e1_q.v   <= {rel_vel_z_i, rel_vel_y_i, rel_vel_x_i};
      e1_q.rad <= radius_a_i;
      e1_q.alx <= 1'b0;
      e1_q.co  <= (center_a_x_i == center_b_x_i) && (center_a_y_i == center_b_y_i)
                  && (center_a_z_i == center_b_z_i);
      d1_q[0]  <= 33'(center_b_x_i) - 33'(center_a_x_i);
      d1_q[1]  <= 33'(center_b_y_i) - 33'(center_a_y_i);
      d1_q[2]  <= 33'(center_b_z_i) - 33'(center_a_z_i);

      e2_q    <= e1_q;
      d2_q    <= d1_q;
      p2_q[0] <= $signed(e1_q.v[1]) * $signed(d1_q[2]);
      q2_q[0] <= $signed(e1_q.v[2]) * $signed(d1_q[1]);
      p2_q[1] <= $signed(e1_q.v[2]) * $signed(d1_q[0]);
      q2_q[1] <= $signed(e1_q.v[0]) * $signed(d1_q[2]);
      p2_q[2] <= $signed(e1_q.v[0]) * $signed(d1_q[1]);
      q2_q[2] <= $signed(e1_q.v[1]) * $signed(d1_q[0]);

      e3_q.co  <= e2_q.co;
      e3_q.alx <= (p2_q[0] == q2_q[0]) && (p2_q[1] == q2_q[1]) && (p2_q[2] == q2_q[2]);
      e3_q.rad <= e2_q.rad;
      e3_q.a   <= e2_q.a;
      e3_q.v   <= e2_q.v;
      d3_q     <= d2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c1_in[i] = {{31{d3_q[i][32]}}, d3_q[i]};
    end
  end

  pcfv_unit #(
    .SideW($bits(s1_t))
  ) u_unit_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .comp_i  (c1_in),
    .side_i  (e3_q),
    .valid_o (u1_v),
    .unit_o  (ez1),
    .side_o  (u1s)
  );

  // fallback perpendicular, sign(0) taken as +1
  always_comb begin
    logic signed [63:0] e0, a1, a2;
    e0 = 64'($signed(ez1[0]));
    a1 = ez1[1][31] ? -64'($signed(ez1[1])) : 64'($signed(ez1[1]));
    a2 = ez1[2][31] ? -64'($signed(ez1[2])) : 64'($signed(ez1[2]));
    fb4_d[0] = -(a1 + a2);
    fb4_d[1] = ez1[1][31] ? -e0 : e0;
    fb4_d[2] = ez1[2][31] ? -e0 : e0;
  end

  assign uzh = uz5_q >>> UNIT_SH;

  // z projection, origin, Gram-Schmidt residue
  always_ff @(posedge clk_i) begin
    if (en) begin
      m4_q.s   <= u1s;
      m4_q.ez  <= ez1;
      m4_q.fb  <= fb4_d;
      m4_q.org <= '0;
      m4_q.fvz <= '0;
      for (int i = 0; i < 3; i++) begin
        pv4_q[i] <= $signed(u1s.v[i]) * $signed(ez1[i]);
        pr4_q[i] <= $signed({1'b0, u1s.rad}) * $signed(ez1[i]);
      end

      m5_q.s   <= m4_q.s;
      m5_q.ez  <= m4_q.ez;
      m5_q.fb  <= m4_q.fb;
      m5_q.fvz <= m4_q.fvz;
      uz5_q <= pv4_q[0] + pv4_q[1] + pv4_q[2];
      for (int i = 0; i < 3; i++) begin
        m5_q.org[i] <= sat32(68'($signed(m4_q.s.a[i])) + rnd_shr(68'(pr4_q[i])));
      end

      m6_q.s   <= m5_q.s;
      m6_q.ez  <= m5_q.ez;
      m6_q.fb  <= m5_q.fb;
      m6_q.org <= m5_q.org;
      m6_q.fvz <= sat32(rnd_shr(68'(uz5_q)));
      for (int i = 0; i < 3; i++) begin
        hu6_q[i] <= $signed(uzh[33:0]) * $signed(m5_q.ez[i]);
        lu6_q[i] <= $signed({1'b0, uz5_q[UNIT_SH-1:0]}) * $signed(m5_q.ez[i]);
      end

      m7_q <= m6_q;
      for (int i = 0; i < 3; i++) begin
        t7_q[i] <= hu6_q[i] + 66'(rnd_shr(68'(lu6_q[i])));
      end

      m8_q <= m7_q;
      for (int i = 0; i < 3; i++) begin
        w8_q[i] <= 64'((66'($signed(m7_q.s.v[i])) <<< UNIT_SH) - t7_q[i]);
      end

      s9_q.co  <= m8_q.s.co;
      s9_q.al  <= m8_q.s.alx || ((w8_q[0] == '0) && (w8_q[1] == '0) && (w8_q[2] == '0));
      s9_q.fvz <= m8_q.fvz;
      s9_q.org <= m8_q.org;
      s9_q.ez  <= m8_q.ez;
      s9_q.v   <= m8_q.s.v;
      for (int i = 0; i < 3; i++) begin
        c9_q[i] <= (m8_q.s.alx || ((w8_q[0] == '0) && (w8_q[1] == '0) && (w8_q[2] == '0)))
                   ? m8_q.fb[i] : w8_q[i];
      end
    end
  end

  pcfv_unit #(
    .SideW($bits(s2_t))
  ) u_unit_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v9_q),
    .comp_i  (c9_q),
    .side_i  (s9_q),
    .valid_o (u2_v),
    .unit_o  (ex2),
    .side_o  (u2s)
  );

  // y axis and frame velocities
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q     <= u2s;
      cp_q[0]  <= $signed(u2s.ez[1]) * $signed(ex2[2]);
      cp_q[1]  <= $signed(ex2[1]) * $signed(u2s.ez[2]);
      cp_q[2]  <= $signed(u2s.ez[2]) * $signed(ex2[0]);
      cp_q[3]  <= $signed(ex2[2]) * $signed(u2s.ez[0]);
      cp_q[4]  <= $signed(u2s.ez[0]) * $signed(ex2[1]);
      cp_q[5]  <= $signed(ex2[0]) * $signed(u2s.ez[1]);
      for (int i = 0; i < 3; i++) begin
        pvx_q[i] <= $signed(u2s.v[i]) * $signed(ex2[i]);
      end

      sb_q <= sa_q;
      for (int i = 0; i < 3; i++) begin
        ey_q[i] <= 34'(rnd_shr(68'(cp_q[2*i]) - 68'(cp_q[2*i+1])));
      end
      ux_q <= 66'(pvx_q[0]) + 66'(pvx_q[1]) + 66'(pvx_q[2]);

      sc_q    <= sb_q;
      fvx_c_q <= sat32(rnd_shr(68'(ux_q)));
      for (int i = 0; i < 3; i++) begin
        pvy_q[i] <= $signed(sb_q.v[i]) * ey_q[i];
      end

      sd_q    <= sc_q;
      fvx_d_q <= fvx_c_q;
      uy_q    <= 68'(pvy_q[0]) + 68'(pvy_q[1]) + 68'(pvy_q[2]);

      co_q <= sd_q.co;
      if (sd_q.co) begin
        fvx_q <= '0;
        fvy_q <= '0;
        fvz_q <= '0;
        ox_q  <= '0;
        oy_q  <= '0;
        oz_q  <= '0;
        al_q  <= 1'b0;
      end else begin
        fvx_q <= fvx_d_q;
        fvy_q <= sat32(rnd_shr(uy_q));
        fvz_q <= sd_q.fvz;
        ox_q  <= sd_q.org[0];
        oy_q  <= sd_q.org[1];
        oz_q  <= sd_q.org[2];
        al_q  <= sd_q.al;
      end
    end
  end

  assign valid_o       = ve_q;
  assign frame_vel_x_o = fvx_q;
  assign frame_vel_y_o = fvy_q;
  assign frame_vel_z_o = fvz_q;
  assign origin_x_o    = ox_q;
  assign origin_y_o    = oy_q;
  assign origin_z_o    = oz_q;
  assign aligned_o     = al_q;
  assign coincident_o  = co_q;

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for pair_contact_frame_velocity: directed and random particle pairs are
// checked against an in-bench predictor of the contact frame, under random idling.
// Depends on pcfv_pkg and the block RTL.
module testbench;
  import pcfv_pkg::*;

  typedef longint vec3_t[3];

  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz, vx, vy, vz;
    logic        [30:0] rad;
  } pair_t;

  typedef struct {
    logic signed [31:0] fvx, fvy, fvz, ox, oy, oz;
    logic               aligned, coincident;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b1;
  logic stall_o, valid_o;
  logic signed [31:0] center_a_x_i = '0, center_a_y_i = '0, center_a_z_i = '0;
  logic signed [31:0] center_b_x_i = '0, center_b_y_i = '0, center_b_z_i = '0;
  logic signed [31:0] rel_vel_x_i = '0, rel_vel_y_i = '0, rel_vel_z_i = '0;
  logic        [30:0] radius_a_i = '0;
  logic signed [31:0] frame_vel_x_o, frame_vel_y_o, frame_vel_z_o;
  logic signed [31:0] origin_x_o, origin_y_o, origin_z_o;
  logic               aligned_o, coincident_o;

  frame_t frame_q[$];
  int     n_err = 0;
  int     n_cyc = 0;
  bit     send_idle = 1'b1;
  bit     recv_idle = 1'b1;
  bit     hold_req = 1'b0;

  pair_contact_frame_velocity DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint rshift_rnd(input longint x);
    return (x + (64'sd1 <<< 29)) >>> UNIT_SH;
  endfunction

  function automatic logic [31:0] clamp32(input longint x);
    if (x > 64'sh7FFFFFFF) return 32'h7FFF_FFFF;
    if (x < -64'sh80000000) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec3_t to_unit(input vec3_t c);
    longint unsigned m[3];
    longint unsigned mx, n2, r, q;
    int rs, ls;
    vec3_t u;
    mx = 0;
    n2 = 0;
    rs = 0;
    ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> rs) >= (64'd1 << UNIT_SH)) rs++;
    while (rs == 0 && (mx << ls) < (64'd1 << (UNIT_SH - 1))) ls++;
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      n2 += m[i] * m[i];
    end
    r = root64(n2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << UNIT_SH) + r / 2) / r;
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic bit cross_zero(input longint a, b, c, e);
    logic signed [127:0] ta, tb, tc, te;
    ta = a;
    tb = b;
    tc = c;
    te = e;
    return (ta * tb) == (tc * te);
  endfunction

  function automatic longint scale_unit(input longint a, input longint u);
    longint lo;
    lo = a & ((64'sd1 <<< UNIT_SH) - 1);
    return (a >>> UNIT_SH) * u + rshift_rnd(lo * u);
  endfunction

  function automatic frame_t contact_frame(input pair_t p);
    vec3_t  a, d, v, ez, ex, ey, w;
    longint uz, ux, uy, s1, s2;
    bit     par;
    frame_t f;
    a = '{p.ax, p.ay, p.az};
    v = '{p.vx, p.vy, p.vz};
    d = '{longint'(p.bx) - p.ax, longint'(p.by) - p.ay, longint'(p.bz) - p.az};
    f = '{default: '0};
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      f.coincident = 1'b1;
      return f;
    end
    ez = to_unit(d);
    uz = 0;
    for (int i = 0; i < 3; i++) uz += v[i] * ez[i];
    par = cross_zero(v[1], d[2], v[2], d[1]) && cross_zero(v[2], d[0], v[0], d[2])
       && cross_zero(v[0], d[1], v[1], d[0]);
    if (!par) begin
      for (int i = 0; i < 3; i++) w[i] = (v[i] <<< UNIT_SH) - scale_unit(uz, ez[i]);
      if (w[0] == 0 && w[1] == 0 && w[2] == 0) par = 1'b1;
      else ex = to_unit(w);
    end
    if (par) begin
      s1 = ez[1] < 0 ? -1 : 1;
      s2 = ez[2] < 0 ? -1 : 1;
      w[0] = -s2 * ez[2] - s1 * ez[1];
      w[1] = s1 * ez[0];
      w[2] = s2 * ez[0];
      ex = to_unit(w);
    end
    ey[0] = rshift_rnd(ez[1] * ex[2] - ex[1] * ez[2]);
    ey[1] = rshift_rnd(ez[2] * ex[0] - ex[2] * ez[0]);
    ey[2] = rshift_rnd(ez[0] * ex[1] - ex[0] * ez[1]);
    ux = 0;
    uy = 0;
    for (int i = 0; i < 3; i++) begin
      ux += v[i] * ex[i];
      uy += v[i] * ey[i];
    end
    f.fvx = clamp32(rshift_rnd(ux));
    f.fvy = clamp32(rshift_rnd(uy));
    f.fvz = clamp32(rshift_rnd(uz));
    f.ox = clamp32(a[0] + rshift_rnd(longint'(p.rad) * ez[0]));
    f.oy = clamp32(a[1] + rshift_rnd(longint'(p.rad) * ez[1]));
    f.oz = clamp32(a[2] + rshift_rnd(longint'(p.rad) * ez[2]));
    f.aligned = par;
    return f;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    n_err++;
  endtask

  always @(posedge clk_i) begin
    frame_t e;
    n_cyc <= n_cyc + 1;
    if (rst_ni && valid_o && !stall_i) begin
      if (frame_q.size() == 0) begin
        report_mismatch("unexpected word", 32'h0, 32'h0);
      end else begin
        e = frame_q.pop_front();
        if (frame_vel_x_o !== e.fvx) report_mismatch("frame_vel_x", frame_vel_x_o, e.fvx);
        if (frame_vel_y_o !== e.fvy) report_mismatch("frame_vel_y", frame_vel_y_o, e.fvy);
        if (frame_vel_z_o !== e.fvz) report_mismatch("frame_vel_z", frame_vel_z_o, e.fvz);
        if (origin_x_o !== e.ox) report_mismatch("origin_x", origin_x_o, e.ox);
        if (origin_y_o !== e.oy) report_mismatch("origin_y", origin_y_o, e.oy);
        if (origin_z_o !== e.oz) report_mismatch("origin_z", origin_z_o, e.oz);
        if (aligned_o !== e.aligned) report_mismatch("aligned", aligned_o, e.aligned);
        if (coincident_o !== e.coincident)
          report_mismatch("coincident", coincident_o, e.coincident);
      end
    end
  end

  always @(posedge clk_i) begin
    if (n_cyc > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long hold-off on request
  initial begin
    int len;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_i = 1'b1;
        for (int k = 0; k < 500; k++) @(negedge clk_i);
        hold_req = 1'b0;
        stall_i = 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        stall_i = 1'b1;
        len = $urandom_range(1, 16);
        for (int k = 1; k < len; k++) @(negedge clk_i);
        stall_i = 1'b0;
      end else begin
        stall_i = 1'b0;
      end
    end
  end

  task automatic send_word(input pair_t p);
    int len;
    if (send_idle && $urandom_range(0, 5) == 0) begin
      valid_i = 1'b0;
      len = $urandom_range(1, 16);
      repeat (len) @(negedge clk_i);
    end
    center_a_x_i = p.ax;
    center_a_y_i = p.ay;
    center_a_z_i = p.az;
    center_b_x_i = p.bx;
    center_b_y_i = p.by;
    center_b_z_i = p.bz;
    rel_vel_x_i = p.vx;
    rel_vel_y_i = p.vy;
    rel_vel_z_i = p.vz;
    radius_a_i = p.rad;
    valid_i = 1'b1;
    do @(posedge clk_i); while (stall_o);
    frame_q = {frame_q, contact_frame(p)};
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd32(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 255) - 128;
      2: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    k, md;
    md = $urandom_range(0, 2);
    p.ax = rnd32($urandom_range(0, 3));
    p.ay = rnd32($urandom_range(0, 3));
    p.az = rnd32($urandom_range(0, 3));
    p.bx = (md == 2 && $urandom_range(0, 1)) ? p.ax : rnd32($urandom_range(0, 3));
    p.by = (md == 2 && $urandom_range(0, 1)) ? p.ay : rnd32($urandom_range(0, 3));
    p.bz = (md == 2 && $urandom_range(0, 1)) ? p.az : rnd32($urandom_range(0, 3));
    p.rad = $urandom >> $urandom_range(1, 31);
    if (md == 1) begin
      // velocity along the axis
      p.ax = $signed($urandom) >>> 12;
      p.ay = $signed($urandom) >>> 12;
      p.az = $signed($urandom) >>> 12;
      p.bx = p.ax + ($signed($urandom) >>> 14);
      p.by = p.ay + ($signed($urandom) >>> 14);
      p.bz = p.az + ($signed($urandom) >>> 14);
      k = $urandom_range(0, 8) - 4;
      p.vx = (p.bx - p.ax) * k;
      p.vy = (p.by - p.ay) * k;
      p.vz = (p.bz - p.az) * k;
    end else begin
      p.vx = rnd32($urandom_range(0, 3));
      p.vy = rnd32($urandom_range(0, 3));
      p.vz = rnd32($urandom_range(0, 3));
    end
    return p;
  endfunction

  function automatic pair_t mk(input logic [31:0] ax, ay, az, bx, by, bz, vx, vy, vz,
                               input logic [30:0] rad);
    pair_t p;
    p = '{ax, ay, az, bx, by, bz, vx, vy, vz, rad};
    return p;
  endfunction

  task automatic test_coincident();
    send_word(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(mk(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 31'h7FFF_FFFF));
  endtask

  task automatic test_aligned();
    send_word(mk(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0003_0000, 0, 0, 31'h0001_0000));
    send_word(mk(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 31'h0000_8000));
    send_word(mk(0, 0, 0, 0, 32'hFFFF_0000, 0, 0, 32'h0002_0000, 0, 31'h0001_0000));
    send_word(mk(0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0002_0000));
    send_word(mk(5, 7, 9, 6, 8, 10, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 3));
  endtask

  task automatic test_extremes();
    send_word(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_word(mk(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
    send_word(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 1));
    send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    send_word(mk(0, 0, 0, 0, 1, 1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 0));
    send_word(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_word(rand_pair());
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    send_idle = 1'b0;
    test_random(250);
    send_idle = 1'b1;
  endtask

  task automatic test_streaming();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    test_random(100);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_coincident();
    test_aligned();
    test_extremes();
    test_random(330);
    test_backpressure();
    test_streaming();
    valid_i = 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
